@@ src/vtf_pkg.sv @@
// ----------------------------------------------------------------------------
// vtf_pkg
// Shared types, codes and constants of the video-transmitter frame link.
// ----------------------------------------------------------------------------
`default_nettype none

package vtf_pkg;

  // Input item kinds (s_axis_tuser)
  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RX   = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Result status codes (m_axis_tuser)
  localparam logic [2:0] ST_TX       = 3'd0;
  localparam logic [2:0] ST_TX_QUERY = 3'd1;
  localparam logic [2:0] ST_TX_DONE  = 3'd2;
  localparam logic [2:0] ST_REPLY_OK = 3'd3;
  localparam logic [2:0] ST_REPLY_BAD = 3'd4;
  localparam logic [2:0] ST_TIMEOUT  = 3'd5;

  // Frame constants
  localparam logic [7:0] FRAME_SYNC  = 8'h0F;
  localparam logic [7:0] CHR_LIMITS  = 8'h72;  // 'r'
  localparam logic [7:0] CHR_STATUS  = 8'h76;  // 'v'
  localparam logic [7:0] CHR_TEMP    = 8'h73;  // 's'
  localparam logic [3:0] IDX_SUM_LAST = 4'd13; // last byte covered by the sum
  localparam logic [3:0] IDX_SUM     = 4'd14;
  localparam logic [3:0] IDX_LAST    = 4'd15;

  localparam int unsigned TIMEOUT_W     = 10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd500;

  // Job queue between front and back end
  localparam int unsigned JOB_FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    JOB_SEND,
    JOB_OK,
    JOB_BAD,
    JOB_TIMEOUT
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  code;   // command to send, or reply command
    logic [15:0] value;  // send argument
    logic        query;  // send of r, v or s
    logic [15:0] w2;     // reply words at byte 2, 4, 6, 8
    logic [15:0] w4;
    logic [15:0] w6;
    logic [15:0] w8;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

  function automatic logic is_query(input logic [7:0] code);
    is_query = (code == CHR_LIMITS) || (code == CHR_STATUS) || (code == CHR_TEMP);
  endfunction

endpackage

`default_nettype wire

@@ src/vtf_fifo.sv @@
// ----------------------------------------------------------------------------
// vtf_fifo
// Small register FIFO carrying jobs from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vtf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ src/vtf_front.sv @@
// ----------------------------------------------------------------------------
// vtf_front
// Accepts input items, tracks the link phase, collects and checks replies,
// runs the silence timer and queues one job per result-producing item.
// ----------------------------------------------------------------------------
`default_nettype none

module vtf_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vtf_pkg::TIMEOUT_W-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic [7:0]                        command_code_i,
  input  logic [15:0]                       request_value_i,
  input  logic [7:0]                        rx_byte_i,
  output logic                              job_push_o,
  output vtf_pkg::job_t                     job_o,
  input  logic                              job_full_i
);

  import vtf_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HUNT    = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;
  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX = '1;

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [1:0]           phase_q, phase_d;
  logic [3:0]           idx_q, idx_d;
  logic [TIMEOUT_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [7:0]           sum_q, sum_d;
  logic [7:0]           rx_store_q [1:14];
  logic                 store_we;
  logic                 accept;
  logic                 reply_ok;

  assign in_ready_o = !job_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign reply_ok    = (rx_store_q[IDX_SUM] == sum_q) && (rx_byte_i == '0);

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // link phase, reply collection and timer
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    elapsed_d  = elapsed_q;
    sum_d      = sum_q;
    store_we   = 1'b0;
    job_push_o = 1'b0;
    job_o      = '{kind: JOB_SEND, code: command_code_i, value: request_value_i,
                   query: is_query(command_code_i),
                   w2: {rx_store_q[3], rx_store_q[2]}, w4: {rx_store_q[5], rx_store_q[4]},
                   w6: {rx_store_q[7], rx_store_q[6]}, w8: {rx_store_q[9], rx_store_q[8]}};
    if (accept) begin
      unique case (cmd_i)
        CMD_SEND: begin
          job_push_o = 1'b1;
          phase_d    = is_query(command_code_i) ? PH_HUNT : PH_IDLE;
          idx_d      = '0;
          elapsed_d  = '0;
        end
        CMD_RX: begin
          if (phase_q == PH_HUNT) begin
            elapsed_d = '0;
            if (rx_byte_i == FRAME_SYNC) begin
              phase_d = PH_COLLECT;
              idx_d   = 4'd1;
              sum_d   = '0;
            end
          end else if (phase_q == PH_COLLECT) begin
            elapsed_d = '0;
            if (idx_q == IDX_LAST) begin
              phase_d    = PH_IDLE;
              idx_d      = '0;
              job_push_o = 1'b1;
              job_o.kind = reply_ok ? JOB_OK : JOB_BAD;
              job_o.code = rx_store_q[1];
            end else begin
              store_we = 1'b1;
              idx_d    = idx_q + 1'b1;
              if (idx_q <= IDX_SUM_LAST) begin
                sum_d = sum_q + rx_byte_i;
              end
            end
          end
        end
        CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (elapsed_inc > timeout_q) begin
              phase_d    = PH_IDLE;
              idx_d      = '0;
              elapsed_d  = '0;
              job_push_o = 1'b1;
              job_o.kind = JOB_TIMEOUT;
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      idx_q     <= '0;
      elapsed_q <= '0;
      sum_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      elapsed_q <= elapsed_d;
      sum_q     <= sum_d;
    end
  end

  // reply byte store, bytes 1 to 14; byte 15 is checked on arrival
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      rx_store_q[idx_q] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ src/vtf_back.sv @@
// ----------------------------------------------------------------------------
// vtf_back
// Turns queued jobs into result transactions: expands a send into its
// 16 frame bytes, reports reply and timeout outcomes, holds decoded settings.
// ----------------------------------------------------------------------------
`default_nettype none

module vtf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vtf_pkg::job_t job_i,
  input  logic          job_empty_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic [7:0]    tx_byte_o,
  output logic          last_o,
  output logic [7:0]    reply_code_o,
  output logic [15:0]   min_frequency_o,
  output logic [15:0]   max_frequency_o,
  output logic [15:0]   max_power_o,
  output logic [15:0]   tuned_frequency_o,
  output logic [15:0]   set_power_o,
  output logic [15:0]   mode_bytes_o,
  output logic [15:0]   actual_power_o,
  output logic [15:0]   temperature_o
);

  import vtf_pkg::*;

  // send sequencer
  logic        active_q, active_d;
  logic [3:0]  beat_q, beat_d;
  logic [7:0]  code_q;
  logic [15:0] value_q;
  logic        query_q;
  logic [7:0]  csum_q;
  logic        load_send;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  tx_q, tx_d;
  logic        last_q, last_d;
  logic [7:0]  rcode_q, rcode_d;
  logic        advance;
  logic        hold_en;

  // held settings
  logic [15:0] min_freq_q, max_freq_q, max_pwr_q;
  logic [15:0] tuned_q, set_pwr_q, mode_q, actual_q, temp_q;

  assign advance = !out_valid_q || out_ready_i;

  function automatic logic [7:0] frame_byte(input logic [3:0] beat, input logic [7:0] code,
                                            input logic [15:0] value, input logic [7:0] csum);
    unique case (beat)
      4'd1:    frame_byte = code;
      4'd2:    frame_byte = value[7:0];
      4'd3:    frame_byte = value[15:8];
      IDX_SUM: frame_byte = csum;
      default: frame_byte = '0;
    endcase
  endfunction

  // next transaction selection
  always_comb begin
    active_d    = active_q;
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    tx_d        = tx_q;
    last_d      = last_q;
    rcode_d     = rcode_q;
    job_pop_o   = 1'b0;
    load_send   = 1'b0;
    hold_en     = 1'b0;
    if (advance) begin
      out_valid_d = 1'b0;
      if (active_q) begin
        out_valid_d = 1'b1;
        tx_d        = frame_byte(beat_q, code_q, value_q, csum_q);
        rcode_d     = '0;
        beat_d      = beat_q + 1'b1;
        if (beat_q == IDX_LAST) begin
          active_d = 1'b0;
          last_d   = 1'b1;
          status_d = query_q ? ST_TX_QUERY : ST_TX_DONE;
        end else begin
          last_d   = 1'b0;
          status_d = ST_TX;
        end
      end else if (!job_empty_i) begin
        job_pop_o   = 1'b1;
        out_valid_d = 1'b1;
        tx_d        = '0;
        rcode_d     = '0;
        last_d      = 1'b1;
        unique case (job_i.kind)
          JOB_SEND: begin
            load_send = 1'b1;
            active_d  = 1'b1;
            beat_d    = 4'd1;
            tx_d      = FRAME_SYNC;
            last_d    = 1'b0;
            status_d  = ST_TX;
          end
          JOB_OK: begin
            hold_en  = 1'b1;
            rcode_d  = job_i.code;
            status_d = ST_REPLY_OK;
          end
          JOB_BAD:     status_d = ST_REPLY_BAD;
          JOB_TIMEOUT: status_d = ST_TIMEOUT;
          default:     status_d = ST_TIMEOUT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    tx_q     <= tx_d;
    last_q   <= last_d;
    rcode_q  <= rcode_d;
    if (load_send) begin
      code_q  <= job_i.code;
      value_q <= job_i.value;
      query_q <= job_i.query;
      csum_q  <= job_i.code + job_i.value[7:0] + job_i.value[15:8];
    end
  end

  // decoded settings, updated by a good reply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q <= '0;
      max_freq_q <= '0;
      max_pwr_q  <= '0;
      tuned_q    <= '0;
      set_pwr_q  <= '0;
      mode_q     <= '0;
      actual_q   <= '0;
      temp_q     <= '0;
    end else if (hold_en) begin
      if (job_i.code == CHR_LIMITS) begin
        min_freq_q <= job_i.w2;
        max_freq_q <= job_i.w4;
        max_pwr_q  <= job_i.w6;
      end else if (job_i.code == CHR_STATUS) begin
        tuned_q   <= job_i.w2;
        set_pwr_q <= job_i.w4;
        mode_q    <= job_i.w6;
        actual_q  <= job_i.w8;
      end else if (job_i.code == CHR_TEMP) begin
        temp_q <= job_i.w6;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign tx_byte_o         = tx_q;
  assign last_o            = last_q;
  assign reply_code_o      = rcode_q;
  assign min_frequency_o   = min_freq_q;
  assign max_frequency_o   = max_freq_q;
  assign max_power_o       = max_pwr_q;
  assign tuned_frequency_o = tuned_q;
  assign set_power_o       = set_pwr_q;
  assign mode_bytes_o      = mode_q;
  assign actual_power_o    = actual_q;
  assign temperature_o     = temp_q;

endmodule

`default_nettype wire

@@ src/vtx_tramp_frame_link.sv @@
// ----------------------------------------------------------------------------
// vtx_tramp_frame_link
// Host side of a 16-byte video-transmitter control link.
// ----------------------------------------------------------------------------
// The input side takes one item (send request, received byte or millisecond
// tick) per clock as long as the job queue between front and back end has a
// free slot. Results leave through a registered output stage, one transaction
// per cycle while the sink is ready: a send request yields 16 consecutive
// transactions, a completed reply or a timeout yields one, everything else none.
// An accepted item passes through the job queue into the output register; the
// back end's one-beat-per-cycle sequencer sets the output rate, and the queue
// depth (FifoDepth) sets how far input can run ahead of a stalled output. Held
// settings on the output reflect every good reply so far, including the current one.
// ----------------------------------------------------------------------------
`default_nettype none

module vtx_tramp_frame_link #(
  parameter int unsigned FifoDepth = vtf_pkg::JOB_FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: reply_timeout_ms
  input  logic                          cfg_we_i,
  input  logic [vtf_pkg::TIMEOUT_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // command_code, request_value, rx_byte
  input  logic [1:0]                    s_axis_tuser,  // cmd
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tx_byte, reply_code, min_frequency, max_frequency, max_power,
  // tuned_frequency, set_power, mode_bytes, actual_power, temperature
  output logic [143:0]                  m_axis_tdata,
  output logic [2:0]                    m_axis_tuser,  // status
  output logic                          m_axis_tlast
);

  import vtf_pkg::*;

  job_t        job_in, job_out;
  logic [JOB_W-1:0] job_rdata;
  logic        job_push, job_pop, job_full, job_empty;
  logic [7:0]  tx_byte, reply_code;
  logic [15:0] min_freq, max_freq, max_pwr, tuned, set_pwr, mode, actual, temp;

  vtf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .cmd_i          (s_axis_tuser),
    .command_code_i (s_axis_tdata[7:0]),
    .request_value_i(s_axis_tdata[23:8]),
    .rx_byte_i      (s_axis_tdata[31:24]),
    .job_push_o     (job_push),
    .job_o          (job_in),
    .job_full_i     (job_full)
  );

  vtf_fifo #(
    .Width(JOB_W),
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(job_rdata),
    .empty_o(job_empty)
  );

  assign job_out = job_t'(job_rdata);

  vtf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (job_out),
    .job_empty_i      (job_empty),
    .job_pop_o        (job_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .status_o         (m_axis_tuser),
    .tx_byte_o        (tx_byte),
    .last_o           (m_axis_tlast),
    .reply_code_o     (reply_code),
    .min_frequency_o  (min_freq),
    .max_frequency_o  (max_freq),
    .max_power_o      (max_pwr),
    .tuned_frequency_o(tuned),
    .set_power_o      (set_pwr),
    .mode_bytes_o     (mode),
    .actual_power_o   (actual),
    .temperature_o    (temp)
  );

  assign m_axis_tdata = {temp, actual, mode, set_pwr, tuned, max_pwr, max_freq, min_freq,
                         reply_code, tx_byte};

endmodule

`default_nettype wire

@@ src/vtf_checker.sv @@
// ----------------------------------------------------------------------------
// vtf_checker
// Port-level checks on the result stream of the frame link.
// ----------------------------------------------------------------------------
`default_nettype none

module vtf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  import vtf_pkg::*;

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // only plain frame bytes continue a run
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != ST_TX)))
    else $error("tlast does not match status");

  // reply code appears only on a good reply
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_REPLY_OK) |-> (m_axis_tdata[15:8] == '0))
    else $error("reply code outside a good reply");

  // reply and timeout results carry no frame byte
  a_txz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_REPLY_OK || m_axis_tuser == ST_REPLY_BAD
      || m_axis_tuser == ST_TIMEOUT) |-> (m_axis_tdata[7:0] == '0))
    else $error("frame byte on a reply result");

endmodule

bind vtx_tramp_frame_link vtf_checker u_vtf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the video-transmitter frame link.
// ----------------------------------------------------------------------------
// Drives send requests, received bytes and millisecond ticks into the input
// stream. A behavioral copy of the link's host side predicts every result
// transaction: frame bytes, reply verdicts, timeouts and the held settings.
// Results are compared field by field in arrival order. Both stream sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vtf_pkg::*;

  localparam int STALL_LIMIT  = 3000;  // cycles without any transaction
  localparam int HOLD_CYCLES  = 200;   // long result-side hold-off
  localparam int DRAIN_CYCLES = 8;     // settle time after the last result
  localparam int RANDOM_ITEMS = 240;
  localparam int SILENCE_MAX  = 1023;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {LINK_IDLE, LINK_HUNT, LINK_COLLECT} link_phase_e;
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;
  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_TRAILER} flaw_e;

  typedef logic [15:0][7:0] frame_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  tx_byte;
    logic        last;
    logic [7:0]  reply_code;
    logic [15:0] min_freq;
    logic [15:0] max_freq;
    logic [15:0] max_power;
    logic [15:0] tuned_freq;
    logic [15:0] set_power;
    logic [15:0] mode_bytes;
    logic [15:0] actual_power;
    logic [15:0] temperature;
  } beat_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [9:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;   // command_code, request_value, rx_byte
  logic [1:0]   s_axis_tuser;   // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // tx_byte, reply_code, min_frequency, max_frequency, max_power,
  // tuned_frequency, set_power, mode_bytes, actual_power, temperature
  logic [143:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;   // status
  logic         m_axis_tlast;

  // Predicted link state
  link_phase_e  link_phase    = LINK_IDLE;
  logic [4:0]   rx_count      = '0;
  frame_t       reply_buf     = '0;
  int           silence_ms    = 0;
  logic [9:0]   reply_timeout = TIMEOUT_RESET;
  logic [15:0]  held_min_freq = '0;
  logic [15:0]  held_max_freq = '0;
  logic [15:0]  held_max_power = '0;
  logic [15:0]  held_tuned    = '0;
  logic [15:0]  held_set_power = '0;
  logic [15:0]  held_mode     = '0;
  logic [15:0]  held_actual   = '0;
  logic [15:0]  held_temp     = '0;

  beat_t        expected_beats[$];
  int           mismatches   = 0;
  int           items_sent   = 0;
  int           quiet_cycles = 0;
  bit           send_idle    = 1'b1;
  bit           recv_idle    = 1'b1;
  bit           hold_output  = 1'b0;

  vtx_tramp_frame_link uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // 8-bit sum of frame bytes 1..13
  function automatic logic [7:0] frame_sum(input frame_t fr);
    logic [7:0] acc;
    int i;
    acc = '0;
    for (i = 1; i <= IDX_SUM_LAST; i++) acc += fr[i];
    return acc;
  endfunction

  // Queue one result carrying the current held settings
  function automatic void push_beat(input logic [2:0] st, input logic [7:0] tx,
                                    input logic lst, input logic [7:0] code);
    beat_t b;
    b.status       = st;
    b.tx_byte      = tx;
    b.last         = lst;
    b.reply_code   = code;
    b.min_freq     = held_min_freq;
    b.max_freq     = held_max_freq;
    b.max_power    = held_max_power;
    b.tuned_freq   = held_tuned;
    b.set_power    = held_set_power;
    b.mode_bytes   = held_mode;
    b.actual_power = held_actual;
    b.temperature  = held_temp;
    expected_beats.push_back(b);
  endfunction

  // Apply one accepted input transaction to the predicted link
  function automatic void advance_link(input logic [1:0] kind, input logic [7:0] code,
                                       input logic [15:0] value, input logic [7:0] rx);
    frame_t fr;
    logic   query;
    int     i;
    fr = '0;
    case (kind)
      CMD_SEND: begin
        query = (code == CHR_LIMITS) || (code == CHR_STATUS) || (code == CHR_TEMP);
        fr[0] = FRAME_SYNC;
        fr[1] = code;
        fr[2] = value[7:0];
        fr[3] = value[15:8];
        fr[IDX_SUM] = frame_sum(fr);
        for (i = 0; i < 15; i++) push_beat(ST_TX, fr[i], 1'b0, 8'h00);
        push_beat(query ? ST_TX_QUERY : ST_TX_DONE, fr[IDX_LAST], 1'b1, 8'h00);
        link_phase = query ? LINK_HUNT : LINK_IDLE;
        rx_count   = '0;
        silence_ms = 0;
      end
      CMD_RX: begin
        if (link_phase == LINK_HUNT) begin
          silence_ms = 0;
          if (rx == FRAME_SYNC) begin
            reply_buf[0] = rx;
            rx_count     = 5'd1;
            link_phase   = LINK_COLLECT;
          end
        end else if (link_phase == LINK_COLLECT) begin
          silence_ms = 0;
          reply_buf[rx_count[3:0]] = rx;
          rx_count = rx_count + 5'd1;
          if (rx_count == 5'd16) begin
            link_phase = LINK_IDLE;
            rx_count   = '0;
            if (reply_buf[IDX_SUM] != frame_sum(reply_buf) || reply_buf[IDX_LAST] != 8'h00) begin
              push_beat(ST_REPLY_BAD, 8'h00, 1'b1, 8'h00);
            end else begin
              case (reply_buf[1])
                CHR_LIMITS: begin
                  held_min_freq  = {reply_buf[3], reply_buf[2]};
                  held_max_freq  = {reply_buf[5], reply_buf[4]};
                  held_max_power = {reply_buf[7], reply_buf[6]};
                end
                CHR_STATUS: begin
                  held_tuned     = {reply_buf[3], reply_buf[2]};
                  held_set_power = {reply_buf[5], reply_buf[4]};
                  held_mode      = {reply_buf[7], reply_buf[6]};
                  held_actual    = {reply_buf[9], reply_buf[8]};
                end
                CHR_TEMP: held_temp = {reply_buf[7], reply_buf[6]};
                default: ;
              endcase
              push_beat(ST_REPLY_OK, 8'h00, 1'b1, reply_buf[1]);
            end
          end
        end
      end
      CMD_TICK: begin
        if (link_phase != LINK_IDLE) begin
          if (silence_ms < SILENCE_MAX) silence_ms++;
          if (silence_ms > reply_timeout) begin
            link_phase = LINK_IDLE;
            rx_count   = '0;
            silence_ms = 0;
            push_beat(ST_TIMEOUT, 8'h00, 1'b1, 8'h00);
          end
        end
      end
      default: ;  // unused kind: no effect
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one item; valid stays high after the transaction so that a
  // back-to-back item needs no second assignment in the same step.
  task automatic put_item(input logic [1:0] kind, input logic [7:0] code,
                          input logic [15:0] value, input logic [7:0] rx);
    int gap;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {rx, value, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_link(kind, code, value, rx);
    items_sent++;
  endtask

  task automatic send_request(input logic [7:0] code, input logic [15:0] value);
    put_item(CMD_SEND, code, value, 8'($urandom));
  endtask

  task automatic rx_in(input logic [7:0] b);
    put_item(CMD_RX, 8'($urandom), 16'($urandom), b);
  endtask

  // Random received byte that is never a frame start
  task automatic rx_noise;
    logic [7:0] b;
    b = 8'($urandom);
    if (b == FRAME_SYNC) b = ~b;
    rx_in(b);
  endtask

  task automatic ms_tick(input int n);
    repeat (n) put_item(CMD_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] pick_query;
    case ($urandom_range(0, 2))
      0:       return CHR_LIMITS;
      1:       return CHR_STATUS;
      default: return CHR_TEMP;
    endcase
  endfunction

  // Feed a 16-byte reply, optionally damaged, with ticks sprinkled in
  task automatic feed_reply(input logic [7:0] code, input fill_e fill,
                            input flaw_e flaw, input int tick_pct);
    frame_t fr;
    int     i;
    fr = '0;
    for (i = 2; i < 14; i++) begin
      case (fill)
        FILL_ONES:  fr[i] = 8'hFF;
        FILL_ZEROS: fr[i] = 8'h00;
        default:    fr[i] = 8'($urandom);
      endcase
    end
    fr[0] = FRAME_SYNC;
    fr[1] = code;
    fr[IDX_SUM] = frame_sum(fr);
    if (flaw == FLAW_SUM) fr[IDX_SUM] = fr[IDX_SUM] ^ 8'($urandom_range(1, 255));
    else if (flaw == FLAW_TRAILER) fr[IDX_LAST] = 8'($urandom_range(1, 255));
    for (i = 0; i < 16; i++) begin
      if ($urandom_range(0, 99) < tick_pct) ms_tick(1);
      rx_in(fr[i]);
    end
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reply_timeout(input logic [9:0] ms);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reply_timeout = ms;
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Ready with random holds; one long hold-off on request
  initial begin : result_sink
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        gap = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        gap = recv_idle ? $urandom_range(0, 12) : 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result: status 0x%0h", m_axis_tuser);
        mismatches++;
      end else begin
        b = expected_beats.pop_front();
        check_field("status", b.status, m_axis_tuser);
        check_field("last", b.last, m_axis_tlast);
        check_field("tx_byte", b.tx_byte, m_axis_tdata[7:0]);
        check_field("reply_code", b.reply_code, m_axis_tdata[15:8]);
        check_field("min_frequency", b.min_freq, m_axis_tdata[31:16]);
        check_field("max_frequency", b.max_freq, m_axis_tdata[47:32]);
        check_field("max_power", b.max_power, m_axis_tdata[63:48]);
        check_field("tuned_frequency", b.tuned_freq, m_axis_tdata[79:64]);
        check_field("set_power", b.set_power, m_axis_tdata[95:80]);
        check_field("mode_bytes", b.mode_bytes, m_axis_tdata[111:96]);
        check_field("actual_power", b.actual_power, m_axis_tdata[127:112]);
        check_field("temperature", b.temperature, m_axis_tdata[143:128]);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Frame generation, sends that cut a pending query, ignored items
  task automatic test_frame_send;
    send_request(8'h00, 16'h0000);
    send_request(8'hFF, 16'hFFFF);
    send_request(8'h41, 16'h1234);
    rx_in(FRAME_SYNC);                      // idle: ignored
    ms_tick(1);                             // idle: ignored
    put_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
    send_request(CHR_LIMITS, 16'hA55A);
    send_request(CHR_STATUS, 16'h5AA5);     // drops the hunt for the r reply
    send_request(CHR_TEMP, 16'hFFFF);
    send_request(8'h50, 16'h00FF);          // non-query ends the hunt
    rx_in(FRAME_SYNC);                      // idle again: ignored
    wait_drained();
  endtask

  // Reply decoding, bad replies and a reply cut by a new send
  task automatic test_reply_decode;
    send_request(CHR_LIMITS, 16'($urandom));
    rx_in(8'h00);
    rx_in(8'hF0);                           // junk before the frame start
    feed_reply(CHR_LIMITS, FILL_ONES, FLAW_NONE, 0);
    send_request(CHR_STATUS, 16'($urandom));
    feed_reply(CHR_STATUS, FILL_RANDOM, FLAW_NONE, 0);
    send_request(CHR_TEMP, 16'($urandom));
    feed_reply(CHR_TEMP, FILL_RANDOM, FLAW_NONE, 0);
    send_request(CHR_LIMITS, 16'($urandom));
    feed_reply(8'h55, FILL_ZEROS, FLAW_NONE, 0);       // unknown code: ok, no update
    send_request(CHR_STATUS, 16'($urandom));
    feed_reply(CHR_STATUS, FILL_ZEROS, FLAW_SUM, 0);
    send_request(CHR_TEMP, 16'($urandom));
    feed_reply(CHR_TEMP, FILL_RANDOM, FLAW_TRAILER, 0);
    send_request(CHR_LIMITS, 16'($urandom));
    rx_in(FRAME_SYNC);
    rx_in(CHR_LIMITS);
    rx_in(8'h12);
    send_request(CHR_STATUS, 16'($urandom));          // partial reply dropped
    feed_reply(CHR_STATUS, FILL_ONES, FLAW_NONE, 0);
    send_request(CHR_LIMITS, 16'($urandom));
    feed_reply(CHR_LIMITS, FILL_ZEROS, FLAW_NONE, 0);
    wait_drained();
  endtask

  // Timeout right at the limit, restart by a byte, timeout while collecting
  task automatic test_reply_timeout;
    send_idle = 1'b0;
    set_reply_timeout(10'd4);
    send_request(CHR_LIMITS, 16'($urandom));
    ms_tick(4);
    rx_in(8'h00);                           // restarts the silence count
    ms_tick(5);
    ms_tick(2);                             // idle: ignored
    set_reply_timeout(10'd1);
    send_request(CHR_STATUS, 16'($urandom));
    ms_tick(1);
    rx_in(FRAME_SYNC);
    ms_tick(2);                             // times out while collecting
    send_idle = 1'b1;
    wait_drained();
  endtask

  // Long result hold-off while requests keep coming: input must stall
  task automatic test_output_backpressure;
    send_idle   = 1'b0;
    hold_output = 1'b1;
    repeat (6) send_request(8'($urandom), 16'($urandom));
    send_idle = 1'b1;
    wait_drained();
  endtask

  // Mostly well-formed query/reply exchanges, with noise and broken ones
  task automatic test_random_traffic;
    int         start_count;
    int         pick;
    logic [7:0] code;
    flaw_e      flaw;
    start_count = items_sent;
    while (items_sent < start_count + RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) set_reply_timeout(10'($urandom_range(1, 6)));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        code = pick_query();
        send_request(code, 16'($urandom));
        repeat ($urandom_range(0, 2)) rx_noise();
        if ($urandom_range(0, 4) == 0) code = 8'($urandom);
        case ($urandom_range(0, 9))
          0:       flaw = FLAW_SUM;
          1:       flaw = FLAW_TRAILER;
          default: flaw = FLAW_NONE;
        endcase
        feed_reply(code, FILL_RANDOM, flaw, 5);
      end else if (pick < 65) begin
        // query left to time out
        send_request(pick_query(), 16'($urandom));
        repeat ($urandom_range(0, 2)) rx_noise();
        ms_tick(reply_timeout + 1);
      end else if (pick < 77) begin
        send_request(8'($urandom), 16'($urandom));
      end else if (pick < 87) begin
        // reply cut short by the next request
        send_request(pick_query(), 16'($urandom));
        rx_in(FRAME_SYNC);
        repeat ($urandom_range(0, 14)) rx_in(8'($urandom));
        send_request(8'($urandom), 16'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          put_item(2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_send();
    test_reply_decode();
    test_reply_timeout();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
